### rtl/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and letter helpers for the playfair encrypt block.
// ----------------------------------------------------------------------------
package pf_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;
    localparam int LTR_W       = $clog2(LETTERS);
    localparam int CELL_W      = $clog2(CELLS + 1);
    localparam int RC_W        = $clog2(SQUARE_SIDE);
    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int ASCII_W     = 7;

    localparam logic [LTR_W-1:0]   IDX_I = LTR_W'(8);
    localparam logic [LTR_W-1:0]   IDX_J = LTR_W'(9);
    localparam logic [LTR_W-1:0]   IDX_X = LTR_W'(23);
    localparam logic [ASCII_W-1:0] ASCII_LOWER_A = 7'h61;

    typedef enum logic [CMD_W-1:0] {
        CMD_START_KEY  = 3'd0,
        CMD_KEY_BYTE   = 3'd1,
        CMD_FINISH_KEY = 3'd2,
        CMD_TEXT_BYTE  = 3'd3,
        CMD_END_TEXT   = 3'd4
    } pf_cmd_code_t;

    typedef enum logic [1:0] {
        OUT_X,
        OUT_Y,
        OUT_END
    } pf_out_sel_t;

    typedef struct packed {
        logic        capture;
        logic        clear_key;
        logic        place_key;
        logic        walk_start;
        logic        walk_step;
        logic        set_pending;
        logic        clear_pending;
        logic        pos_read;
        logic        pair_with_x;
        logic        key_read;
        logic        out_load;
        pf_out_sel_t out_sel;
    } pf_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             letter_ok;
        logic             pending_valid;
        logic             same_letter;
        logic             walk_last;
        logic             out_free;
    } pf_status_t;

    function automatic logic is_letter(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
    endfunction

    function automatic logic [LTR_W-1:0] letter_idx(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        logic [LTR_W-1:0]  idx;
        if (b <= 8'h5a) begin
            d = b - 8'h41;
        end else begin
            d = b - 8'h61;
        end
        idx = d[LTR_W-1:0];
        if (idx == IDX_J) begin
            idx = IDX_I;
        end
        return idx;
    endfunction

    function automatic logic [RC_W-1:0] row_of(input logic [CELL_W-1:0] pos);
        logic [RC_W-1:0] row;
        row = '0;
        for (int r = 1; r < SQUARE_SIDE; r++) begin
            if (pos >= CELL_W'(r * SQUARE_SIDE)) begin
                row = RC_W'(r);
            end
        end
        return row;
    endfunction

    function automatic logic [RC_W-1:0] col_of(input logic [CELL_W-1:0] pos);
        logic [CELL_W-1:0] base;
        logic [CELL_W-1:0] diff;
        base = CELL_W'(row_of(pos) * SQUARE_SIDE);
        diff = pos - base;
        return diff[RC_W-1:0];
    endfunction

    function automatic logic [RC_W-1:0] next_rc(input logic [RC_W-1:0] v);
        return (v == RC_W'(SQUARE_SIDE - 1)) ? '0 : RC_W'(v + 1'b1);
    endfunction

    function automatic logic [CELL_W-1:0] cell_of(input logic [RC_W-1:0] row,
                                                  input logic [RC_W-1:0] col);
        return CELL_W'(row * SQUARE_SIDE) + CELL_W'(col);
    endfunction

    function automatic logic [ASCII_W-1:0] to_ascii(input logic [LTR_W-1:0] idx);
        return ASCII_LOWER_A + ASCII_W'(idx);
    endfunction

endpackage

### rtl/pf_ctrl.sv
// ----------------------------------------------------------------------------
// pf_ctrl
// Controller: sequences key loading, key finish walk and pair encryption.
// ----------------------------------------------------------------------------
module pf_ctrl
    import pf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pf_status_t sts,
    output pf_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_CELL,
        ST_EMIT_X,
        ST_EMIT_Y,
        ST_EMIT_END
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;

    assign s_ready = s_ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.command)
                    CMD_START_KEY: begin
                        cmd.clear_key = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    CMD_KEY_BYTE: begin
                        cmd.place_key = sts.letter_ok;
                        state_next    = ST_IDLE;
                    end
                    CMD_FINISH_KEY: begin
                        cmd.walk_start = 1'b1;
                        state_next     = ST_FILL;
                    end
                    CMD_TEXT_BYTE: begin
                        if (!sts.letter_ok) begin
                            state_next = ST_IDLE;
                        end else if (!sts.pending_valid) begin
                            cmd.set_pending = 1'b1;
                            state_next      = ST_IDLE;
                        end else begin
                            cmd.pos_read      = 1'b1;
                            cmd.pair_with_x   = sts.same_letter;
                            cmd.clear_pending = !sts.same_letter;
                            state_next        = ST_CELL;
                        end
                    end
                    CMD_END_TEXT: begin
                        if (sts.pending_valid) begin
                            cmd.pos_read      = 1'b1;
                            cmd.pair_with_x   = 1'b1;
                            cmd.clear_pending = 1'b1;
                            state_next        = ST_CELL;
                        end else begin
                            state_next = ST_EMIT_END;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FILL: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CELL: begin
                cmd.key_read = 1'b1;
                state_next   = ST_EMIT_X;
            end
            ST_EMIT_X: begin
                cmd.out_sel = OUT_X;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_EMIT_Y;
                end
            end
            ST_EMIT_Y: begin
                cmd.out_sel = OUT_Y;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT_END: begin
                cmd.out_sel = OUT_END;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

### rtl/pf_datapath.sv
// ----------------------------------------------------------------------------
// pf_datapath
// Datapath: key square and position stores, pending letter, pair lookup
// and the result register.
// ----------------------------------------------------------------------------
module pf_datapath
    import pf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [BYTE_W-1:0]   s_input_byte,
    input  pf_cmd_t             cmd,
    output pf_status_t          sts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ASCII_W-1:0]  m_cipher_letter,
    output logic                m_has_letter,
    output logic                m_is_last
);

    logic [LTR_W-1:0]  key_square_mem [CELLS];
    logic [CELL_W-1:0] letter_position_mem [LETTERS];

    logic [LETTERS-1:0] used_reg;
    logic [CELL_W-1:0]  fill_count_reg;
    logic [LTR_W-1:0]   walk_k_reg;
    logic               pending_valid_reg;
    logic [LTR_W-1:0]   pending_letter_reg;
    logic [CMD_W-1:0]   cmd_code_reg;
    logic               letter_ok_reg;
    logic [LTR_W-1:0]   letter_reg;
    logic [CELL_W-1:0]  pos_a_reg;
    logic [CELL_W-1:0]  pos_b_reg;
    logic [LTR_W-1:0]   ltr_x_reg;
    logic [LTR_W-1:0]   ltr_y_reg;
    logic               m_valid_reg;
    logic [ASCII_W-1:0] m_cipher_letter_reg;
    logic               m_has_letter_reg;
    logic               m_is_last_reg;

    logic [LTR_W-1:0]  place_idx;
    logic              place_go;
    logic [LTR_W-1:0]  addr_b;
    logic [RC_W-1:0]   r1, c1, r2, c2;
    logic [CELL_W-1:0] cell_x, cell_y;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    assign sts.command       = cmd_code_reg;
    assign sts.letter_ok     = letter_ok_reg;
    assign sts.pending_valid = pending_valid_reg;
    assign sts.same_letter   = (letter_reg == pending_letter_reg);
    assign sts.walk_last     = (walk_k_reg == LTR_W'(LETTERS - 1));
    assign sts.out_free      = out_free;

    // placement of one letter, from a key byte or the finish walk
    assign place_idx = cmd.walk_step ? walk_k_reg : letter_reg;
    assign place_go  = (cmd.place_key || (cmd.walk_step && (walk_k_reg != IDX_J)))
                       && !used_reg[place_idx] && (fill_count_reg < CELL_W'(CELLS));

    assign addr_b = cmd.pair_with_x ? IDX_X : letter_reg;

    // row, column and rectangle rules
    assign r1 = row_of(pos_a_reg);
    assign c1 = col_of(pos_a_reg);
    assign r2 = row_of(pos_b_reg);
    assign c2 = col_of(pos_b_reg);

    always_comb begin
        if (r1 == r2) begin
            cell_x = cell_of(r1, next_rc(c1));
            cell_y = cell_of(r2, next_rc(c2));
        end else if (c1 == c2) begin
            cell_x = cell_of(next_rc(r1), c1);
            cell_y = cell_of(next_rc(r2), c2);
        end else begin
            cell_x = cell_of(r1, c2);
            cell_y = cell_of(r2, c1);
        end
    end

    always_ff @(posedge aclk) begin
        if (place_go) begin
            key_square_mem[fill_count_reg]  <= place_idx;
            letter_position_mem[place_idx]  <= fill_count_reg;
        end
        if (cmd.pos_read) begin
            pos_a_reg <= letter_position_mem[pending_letter_reg];
            pos_b_reg <= letter_position_mem[addr_b];
        end
        if (cmd.key_read) begin
            ltr_x_reg <= key_square_mem[cell_x];
            ltr_y_reg <= key_square_mem[cell_y];
        end
        if (cmd.capture) begin
            letter_ok_reg <= is_letter(s_input_byte);
            letter_reg    <= letter_idx(s_input_byte);
        end
        if (cmd.walk_start) begin
            walk_k_reg <= '0;
        end else if (cmd.walk_step) begin
            walk_k_reg <= walk_k_reg + 1'b1;
        end
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OUT_X: begin
                    m_cipher_letter_reg <= to_ascii(ltr_x_reg);
                    m_has_letter_reg    <= 1'b1;
                    m_is_last_reg       <= 1'b0;
                end
                OUT_Y: begin
                    m_cipher_letter_reg <= to_ascii(ltr_y_reg);
                    m_has_letter_reg    <= 1'b1;
                    m_is_last_reg       <= (cmd_code_reg == CMD_END_TEXT);
                end
                OUT_END: begin
                    m_cipher_letter_reg <= '0;
                    m_has_letter_reg    <= 1'b0;
                    m_is_last_reg       <= 1'b1;
                end
                default: begin
                    m_cipher_letter_reg <= '0;
                    m_has_letter_reg    <= 1'b0;
                    m_is_last_reg       <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg           <= '0;
            fill_count_reg     <= '0;
            pending_valid_reg  <= 1'b0;
            pending_letter_reg <= '0;
            cmd_code_reg       <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cmd.capture) begin
                cmd_code_reg <= s_command;
            end
            if (cmd.clear_key) begin
                used_reg           <= '0;
                fill_count_reg     <= '0;
                pending_valid_reg  <= 1'b0;
                pending_letter_reg <= '0;
            end else begin
                if (place_go) begin
                    used_reg[place_idx] <= 1'b1;
                    fill_count_reg      <= fill_count_reg + 1'b1;
                end
                if (cmd.set_pending) begin
                    pending_valid_reg  <= 1'b1;
                    pending_letter_reg <= letter_reg;
                end else if (cmd.clear_pending) begin
                    pending_valid_reg  <= 1'b0;
                    pending_letter_reg <= '0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cipher_letter = m_cipher_letter_reg;
    assign m_has_letter    = m_has_letter_reg;
    assign m_is_last       = m_is_last_reg;

endmodule

### rtl/playfair_cipher_encrypt.sv
// order: a text byte that completes a pair has its positions read, then its key
//   cells, then emits its first and second letter as the result frees; end text alone emits the end marker
// throughput: one item at a time; finish key walks the alphabet one letter per cycle
// reset: synchronous active low aresetn clears the controller, the used letter
//   flags, fill count, pending letter and the valid flag of the result register
// ----------------------------------------------------------------------------
// playfair_cipher_encrypt
// Playfair 5x5 encryption over a byte stream of key and text commands.
// ----------------------------------------------------------------------------
module playfair_cipher_encrypt
    import pf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CMD_W-1:0]   s_command,
    input  logic [BYTE_W-1:0]  s_input_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ASCII_W-1:0] m_cipher_letter,
    output logic               m_has_letter,
    output logic               m_is_last
);

    pf_cmd_t    cmd;
    pf_status_t sts;

    pf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_command       (s_command),
        .s_input_byte    (s_input_byte),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_letter (m_cipher_letter),
        .m_has_letter    (m_has_letter),
        .m_is_last       (m_is_last)
    );

endmodule

### rtl/pf_checker.sv
// ----------------------------------------------------------------------------
// pf_checker
// Port-level checks for the playfair encrypt block, bound to the top level.
// ----------------------------------------------------------------------------
module pf_checker
    import pf_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [CMD_W-1:0]   s_command,
    input logic [BYTE_W-1:0]  s_input_byte,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ASCII_W-1:0] m_cipher_letter,
    input logic               m_has_letter,
    input logic               m_is_last
);

    // one transaction in flight at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while previous transaction still in work");

    // waiting input transaction holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_command)
            && $stable(s_input_byte)))
        else $error("input changed while waiting");

    // a result without a letter is the bare end-of-text marker
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_letter) |-> (m_is_last && (m_cipher_letter == '0)))
        else $error("empty result is not an end marker");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_cipher_letter)
            && $stable(m_has_letter) && $stable(m_is_last)))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind playfair_cipher_encrypt pf_checker u_pf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_command       (s_command),
    .s_input_byte    (s_input_byte),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_cipher_letter (m_cipher_letter),
    .m_has_letter    (m_has_letter),
    .m_is_last       (m_is_last)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Playfair encrypt stream check: a directed table of key and text commands,
// then random key/text messages and noise under four idling phases. Every
// result transaction is compared with the table or a cipher predictor in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import pf_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 40;
    localparam int DIR_ROWS     = 28;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ASCII_W-1:0] letter;
        logic               has;
        logic               last;
    } cipher_out_t;

    localparam cipher_out_t NO_LETTER = '0;
    localparam cipher_out_t LAST_ONLY = '{letter: '0, has: 1'b0, last: 1'b1};

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] b;
        int                typed_n;
        cipher_out_t       t0;
        cipher_out_t       t1;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_command = '0;
    logic [BYTE_W-1:0]  s_input_byte = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [ASCII_W-1:0] m_cipher_letter;
    logic               m_has_letter;
    logic               m_is_last;

    // predictor state
    logic [LTR_W-1:0]  sq_letter [CELLS];
    logic [CELL_W-1:0] sq_pos [LETTERS];
    bit                sq_used [LETTERS];
    int                sq_fill;
    bit                pend_valid;
    logic [LTR_W-1:0]  pend_letter;

    cipher_out_t expected_letters [$];
    int          errors = 0;
    int          counted_items = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    dir_row_t    dir_steps [DIR_ROWS];

    playfair_cipher_encrypt u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_input_byte    (s_input_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cipher_letter (m_cipher_letter),
        .m_has_letter    (m_has_letter),
        .m_is_last       (m_is_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit decode_letter(input logic [BYTE_W-1:0] b,
                                         output logic [LTR_W-1:0] li);
        int v;
        v = int'(b);
        li = '0;
        if (v >= 8'h41 && v <= 8'h5a) begin
            li = LTR_W'(v - 8'h41);
        end else if (v >= 8'h61 && v <= 8'h7a) begin
            li = LTR_W'(v - 8'h61);
        end else begin
            return 1'b0;
        end
        if (li == IDX_J) begin
            li = IDX_I;
        end
        return 1'b1;
    endfunction

    function automatic void place_letter(input logic [LTR_W-1:0] li);
        if (sq_used[li] || sq_fill >= CELLS) begin
            return;
        end
        sq_letter[sq_fill] = li;
        sq_pos[li] = CELL_W'(sq_fill);
        sq_used[li] = 1'b1;
        sq_fill++;
    endfunction

    function automatic logic [ASCII_W-1:0] cell_char(input int row, input int col);
        return ASCII_LOWER_A + ASCII_W'(sq_letter[row * SQUARE_SIDE + col]);
    endfunction

    function automatic void cipher_pair(input logic [LTR_W-1:0] a,
                                        input logic [LTR_W-1:0] bb,
                                        output cipher_out_t x,
                                        output cipher_out_t y);
        int pa, pb, r1, c1, r2, c2;
        pa = int'(sq_pos[a]);
        pb = int'(sq_pos[bb]);
        r1 = pa / SQUARE_SIDE;
        c1 = pa % SQUARE_SIDE;
        r2 = pb / SQUARE_SIDE;
        c2 = pb % SQUARE_SIDE;
        x = '{letter: '0, has: 1'b1, last: 1'b0};
        y = x;
        if (r1 == r2) begin
            x.letter = cell_char(r1, (c1 + 1) % SQUARE_SIDE);
            y.letter = cell_char(r2, (c2 + 1) % SQUARE_SIDE);
        end else if (c1 == c2) begin
            x.letter = cell_char((r1 + 1) % SQUARE_SIDE, c1);
            y.letter = cell_char((r2 + 1) % SQUARE_SIDE, c2);
        end else begin
            x.letter = cell_char(r1, c2);
            y.letter = cell_char(r2, c1);
        end
    endfunction

    function automatic void cipher_predict(input logic [CMD_W-1:0] cmd,
                                           input logic [BYTE_W-1:0] b,
                                           output int n,
                                           output cipher_out_t r0,
                                           output cipher_out_t r1,
                                           output bit ignored);
        bit               ok;
        logic [LTR_W-1:0] li;
        n = 0;
        r0 = NO_LETTER;
        r1 = NO_LETTER;
        ignored = 1'b0;
        ok = decode_letter(b, li);
        case (cmd)
            CMD_START_KEY: begin
                foreach (sq_used[k]) sq_used[k] = 1'b0;
                sq_fill = 0;
                pend_valid = 1'b0;
                pend_letter = '0;
            end
            CMD_KEY_BYTE: begin
                if (ok) place_letter(li);
                else ignored = 1'b1;
            end
            CMD_FINISH_KEY: begin
                for (int k = 0; k < LETTERS; k++) begin
                    if (LTR_W'(k) != IDX_J) place_letter(LTR_W'(k));
                end
            end
            CMD_TEXT_BYTE: begin
                if (!ok) begin
                    ignored = 1'b1;
                end else if (!pend_valid) begin
                    pend_valid = 1'b1;
                    pend_letter = li;
                end else if (li == pend_letter) begin
                    cipher_pair(pend_letter, IDX_X, r0, r1);
                    n = 2;
                end else begin
                    cipher_pair(pend_letter, li, r0, r1);
                    n = 2;
                    pend_valid = 1'b0;
                    pend_letter = '0;
                end
            end
            CMD_END_TEXT: begin
                if (!pend_valid) begin
                    r0 = LAST_ONLY;
                    n = 1;
                end else begin
                    cipher_pair(pend_letter, IDX_X, r0, r1);
                    r1.last = 1'b1;
                    n = 2;
                    pend_valid = 1'b0;
                    pend_letter = '0;
                end
            end
            default: ignored = 1'b1;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b,
                             input int typed_n = 0,
                             input cipher_out_t t0 = '0, input cipher_out_t t1 = '0);
        int          n;
        cipher_out_t r0, r1;
        bit          ignored;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_input_byte <= b;
        do @(posedge aclk); while (!s_ready);
        cipher_predict(cmd, b, n, r0, r1, ignored);
        if (typed_n > 0) begin
            n = typed_n;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0) expected_letters.push_back(r0);
        if (n > 1) expected_letters.push_back(r1);
        if (!ignored) counted_items++;
        @(negedge aclk);
    endtask

    task automatic drain_letters();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_letters.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] letter_byte(input int idx);
        return BYTE_W'(($urandom_range(1) ? 8'h41 : 8'h61) + idx);
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        return BYTE_W'($urandom_range(255));
    endfunction

    task automatic send_message();
        int nkey, ntext, rot, prev, cur;
        if ($urandom_range(3) != 0) begin
            send_item(CMD_START_KEY, noise_byte());
            if ($urandom_range(9) == 0) begin
                rot = $urandom_range(25);
                for (int k = 0; k < LETTERS + 2; k++) begin
                    send_item(CMD_KEY_BYTE, letter_byte((k + rot) % LETTERS));
                end
            end else begin
                nkey = $urandom_range(12);
                for (int k = 0; k < nkey; k++) begin
                    if ($urandom_range(9) == 0) send_item(CMD_KEY_BYTE, noise_byte());
                    else send_item(CMD_KEY_BYTE, letter_byte($urandom_range(25)));
                end
            end
            if ($urandom_range(9) != 0) send_item(CMD_FINISH_KEY, noise_byte());
            if ($urandom_range(9) == 0) send_item(CMD_FINISH_KEY, noise_byte());
        end
        ntext = $urandom_range(15);
        prev = $urandom_range(25);
        for (int k = 0; k < ntext; k++) begin
            case ($urandom_range(9))
                0: send_item(CMD_TEXT_BYTE, noise_byte());
                1: send_item(CMD_TEXT_BYTE, letter_byte($urandom_range(1) ? 23 : 9));
                2, 3: send_item(CMD_TEXT_BYTE, letter_byte(prev));
                default: begin
                    cur = $urandom_range(25);
                    prev = cur;
                    send_item(CMD_TEXT_BYTE, letter_byte(cur));
                end
            endcase
        end
        if ($urandom_range(9) != 0) send_item(CMD_END_TEXT, noise_byte());
    endtask

    task automatic send_noise();
        int nnoise;
        nnoise = $urandom_range(1, 4);
        for (int k = 0; k < nnoise; k++) begin
            send_item(CMD_W'($urandom_range(7)), noise_byte());
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cipher_out_t exp_out;
        if (aresetn && m_valid && m_ready) begin
            if (expected_letters.size() == 0) begin
                errors++;
                $display("%0t unexpected transaction: letter %h has %b last %b",
                         $time, m_cipher_letter, m_has_letter, m_is_last);
            end else begin
                exp_out = expected_letters.pop_front();
                if (m_cipher_letter !== exp_out.letter) begin
                    errors++;
                    $display("%0t cipher_letter expected %h got %h",
                             $time, exp_out.letter, m_cipher_letter);
                end
                if (m_has_letter !== exp_out.has) begin
                    errors++;
                    $display("%0t has_letter expected %b got %b",
                             $time, exp_out.has, m_has_letter);
                end
                if (m_is_last !== exp_out.last) begin
                    errors++;
                    $display("%0t is_last expected %b got %b",
                             $time, exp_out.last, m_is_last);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase, last_phase;
        int idle_by_phase [4];
        int stall_by_phase [4];
        idle_by_phase = '{0, 72, 0, 37};
        stall_by_phase = '{0, 0, 72, 37};
        dir_steps = '{
            '{CMD_END_TEXT,   8'h00, 1, LAST_ONLY, NO_LETTER},
            '{CMD_START_KEY,  8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_FINISH_KEY, 8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h61, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h42, 2, '{7'h62, 1'b1, 1'b0}, '{7'h63, 1'b1, 1'b0}},
            '{CMD_TEXT_BYTE,  8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'hff, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h6a, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h49, 0, NO_LETTER, NO_LETTER},
            '{CMD_END_TEXT,   8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_SPARE_LO,   8'hff, 0, NO_LETTER, NO_LETTER},
            '{CMD_SPARE_HI,   8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_START_KEY,  8'hff, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h5a, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h4a, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h40, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h69, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h78, 0, NO_LETTER, NO_LETTER},
            '{CMD_FINISH_KEY, 8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_FINISH_KEY, 8'hff, 0, NO_LETTER, NO_LETTER},
            '{CMD_KEY_BYTE,   8'h71, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h78, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h58, 0, NO_LETTER, NO_LETTER},
            '{CMD_END_TEXT,   8'hff, 0, NO_LETTER, NO_LETTER},
            '{CMD_START_KEY,  8'h00, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h7a, 0, NO_LETTER, NO_LETTER},
            '{CMD_TEXT_BYTE,  8'h41, 0, NO_LETTER, NO_LETTER},
            '{CMD_END_TEXT,   8'h00, 1, LAST_ONLY, NO_LETTER}
        };

        foreach (sq_letter[k]) sq_letter[k] = '0;
        foreach (sq_pos[k]) sq_pos[k] = '0;
        foreach (sq_used[k]) sq_used[k] = 1'b0;
        sq_fill = 0;
        pend_valid = 1'b0;
        pend_letter = '0;

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_steps[i]) begin
            send_item(dir_steps[i].cmd, dir_steps[i].b, dir_steps[i].typed_n,
                      dir_steps[i].t0, dir_steps[i].t1);
        end
        drain_letters();

        counted_items = 0;
        last_phase = -1;
        while (counted_items < RANDOM_ITEMS) begin
            phase = counted_items * 4 / RANDOM_ITEMS;
            if (phase > 3) phase = 3;
            if (phase != last_phase) begin
                // sender holds off until every pending letter is out
                drain_letters();
                send_idle_pct = idle_by_phase[phase];
                recv_stall_pct = stall_by_phase[phase];
                last_phase = phase;
            end
            if ($urandom_range(99) < 85) send_message();
            else send_noise();
        end

        drain_letters();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
